[hw/rtl/utf8e_pkg.sv]
`timescale 1ns / 1ps

package utf8e_pkg;

    // Result kinds
    localparam logic [2:0] KIND_LIT   = 3'd0;
    localparam logic [2:0] KIND_U4    = 3'd1;
    localparam logic [2:0] KIND_U8    = 3'd2;
    localparam logic [2:0] KIND_BAD   = 3'd3;
    localparam logic [2:0] KIND_TRUNC = 3'd4;

    // Encoding modes (code 3 falls back to utf8)
    localparam logic [1:0] MODE_UTF8   = 2'd0;
    localparam logic [1:0] MODE_LATIN1 = 2'd1;
    localparam logic [1:0] MODE_MIXED  = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENC_MODE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SURR_PAIR = 1'b1;

    localparam int unsigned CP_W = 21;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [1:0] bytes_after;
    } t_in_item;

    typedef struct packed {
        logic [2:0]      kind;
        logic [CP_W-1:0] value;
        logic            last_of_run;
    } t_out_item;

    // Decoder state carried between bytes of one string
    typedef struct packed {
        logic [1:0]      bytes_pending;
        logic [CP_W-1:0] code_accum;
        logic            drop_rest;
    } t_dec_state;

    // Configuration as seen by the decoder
    typedef struct packed {
        logic [1:0] encoding_mode;
        logic       surrogate_pairs;
    } t_dec_cfg;

endpackage

[hw/rtl/utf8_string_escaper_unit.sv]
`timescale 1ns / 1ps

// Channel   Valid     Stall     Payload
// input     i_valid   o_stall   i_data  (t_in_item)
// output    o_valid   i_stall   o_data  (t_out_item)
// config    i_cfg_we  -         i_cfg_idx, i_cfg_data
//
// One byte per cycle while the output is not stalled; a byte that yields a
// surrogate pair fills both result slots, and a following result waits for the pair.
// Path: input register, then decode into the result register.
// Synchronous active-low reset clears state and sets utf8 with surrogate pairs.
// Output stall backs up through the result register into the input register.
module utf8_string_escaper_unit
    import utf8e_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_in_item              i_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_out_item             o_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dec_cfg   r_cfg;
    logic       r_in_valid;
    t_in_item   r_in;
    t_dec_state r_state;
    t_out_item  r_res0;
    t_out_item  r_res1;
    logic [1:0] r_cnt;

    t_dec_state n_state;
    logic [1:0] dec_cnt;
    t_out_item  dec_res0;
    t_out_item  dec_res1;
    logic       out_take;
    logic       res_free;
    logic       move;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{encoding_mode: MODE_UTF8, surrogate_pairs: 1'b1};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENC_MODE:  r_cfg.encoding_mode   <= i_cfg_data[1:0];
                CFG_SURR_PAIR: r_cfg.surrogate_pairs <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    utf8e_decode u_decode (
        .i_item  (r_in),
        .i_state (r_state),
        .i_cfg   (r_cfg),
        .o_state (n_state),
        .o_count (dec_cnt),
        .o_res0  (dec_res0),
        .o_res1  (dec_res1)
    );

    // Handshake control
    assign out_take = o_valid && !i_stall;
    assign res_free = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && out_take);
    assign move     = r_in_valid && ((dec_cnt == 2'd0) || res_free);
    assign o_stall  = r_in_valid && !move;
    assign o_valid  = (r_cnt != 2'd0);
    assign o_data   = r_res0;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in <= i_data;
        end
    end

    // Decoder state advances as each item leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (move) begin
            r_state <= n_state;
        end
    end

    // Result register, two slots drained one per cycle while the output is not stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (move && (dec_cnt != 2'd0)) begin
            r_cnt <= dec_cnt;
        end else if (out_take) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move && (dec_cnt != 2'd0)) begin
            r_res0 <= dec_res0;
            r_res1 <= dec_res1;
        end else if (out_take) begin
            r_res0 <= r_res1;
        end
    end

    // Checks
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result count out of range");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move && (r_in.bytes_after == 2'd0)) |=> (r_state == '0))
        else $error("state not cleared at end of string");

    a_drop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.drop_rest |-> (r_state.bytes_pending == 2'd0))
        else $error("sequence pending while dropping");

    a_pair_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> (!r_res0.last_of_run && r_res1.last_of_run))
        else $error("last_of_run misplaced in pair");

endmodule

[hw/rtl/utf8e_decode.sv]
`timescale 1ns / 1ps

// Per-byte decode: next state plus up to two results
module utf8e_decode
    import utf8e_pkg::*;
(
    input  t_in_item   i_item,
    input  t_dec_state i_state,
    input  t_dec_cfg   i_cfg,
    output t_dec_state o_state,
    output logic [1:0] o_count,
    output t_out_item  o_res0,
    output t_out_item  o_res1
);

    always_comb begin
        logic [7:0]      b;
        logic [1:0]      after;
        logic            plain;
        logic            emit_cp;
        logic [CP_W-1:0] cp;
        logic [CP_W-1:0] off;
        logic [CP_W-1:0] acc_new;
        logic            do_fail;
        logic [2:0]      fail_kind;
        logic            do_start;
        logic [1:0]      need;
        logic [CP_W-1:0] start_bits;
        logic [1:0]      cnt;

        b          = i_item.data_byte;
        after      = i_item.bytes_after;
        plain      = (b inside {[8'd32:8'd127]}) && (b != 8'd34) && (b != 8'd92);
        emit_cp    = 1'b0;
        cp         = '0;
        acc_new    = {i_state.code_accum[CP_W-7:0], b[5:0]};
        do_fail    = 1'b0;
        fail_kind  = KIND_BAD;
        do_start   = 1'b0;
        need       = 2'd0;
        start_bits = '0;
        cnt        = 2'd0;
        o_state    = i_state;
        o_res0     = '0;
        o_res1     = '0;

        if (i_state.drop_rest) begin
            // error already reported: swallow the rest of the string
        end else if (i_state.bytes_pending != 2'd0) begin
            // continuation byte
            if (b[7:6] != 2'b10) begin
                do_fail = 1'b1;
            end else begin
                o_state.code_accum    = acc_new;
                o_state.bytes_pending = i_state.bytes_pending - 2'd1;
                if (i_state.bytes_pending == 2'd1) begin
                    emit_cp            = 1'b1;
                    cp                 = acc_new;
                    o_state.code_accum = '0;
                end else if (after == 2'd0) begin
                    do_fail   = 1'b1;
                    fail_kind = KIND_TRUNC;
                end
            end
        end else if (i_cfg.encoding_mode == MODE_LATIN1) begin
            if (plain) begin
                cnt    = 2'd1;
                o_res0 = '{kind: KIND_LIT, value: CP_W'(b), last_of_run: 1'b0};
            end else begin
                emit_cp = 1'b1;
                cp      = CP_W'(b);
            end
        end else if (i_cfg.encoding_mode == MODE_MIXED) begin
            if (plain) begin
                cnt    = 2'd1;
                o_res0 = '{kind: KIND_LIT, value: CP_W'(b), last_of_run: 1'b0};
            end else if (b[7:5] == 3'b110) begin
                do_start   = 1'b1;
                need       = 2'd1;
                start_bits = CP_W'(b[4:0]);
            end else begin
                emit_cp = 1'b1;
                cp      = CP_W'(b);
            end
        end else begin
            // utf8 lead byte
            if (b[7] == 1'b0) begin
                if (plain) begin
                    cnt    = 2'd1;
                    o_res0 = '{kind: KIND_LIT, value: CP_W'(b), last_of_run: 1'b0};
                end else begin
                    emit_cp = 1'b1;
                    cp      = CP_W'(b);
                end
            end else if (b[7:5] == 3'b110) begin
                if (b[4:1] == 4'd0) begin
                    do_fail = 1'b1;    // overlong two-byte lead
                end else begin
                    do_start   = 1'b1;
                    need       = 2'd1;
                    start_bits = CP_W'(b[4:0]);
                end
            end else if (b[7:4] == 4'b1110) begin
                do_start   = 1'b1;
                need       = 2'd2;
                start_bits = CP_W'(b[3:0]);
            end else if (b[7:3] == 5'b11110) begin
                if (b >= 8'hF5) begin
                    do_fail = 1'b1;
                end else begin
                    do_start   = 1'b1;
                    need       = 2'd3;
                    start_bits = CP_W'(b[2:0]);
                end
            end else begin
                do_fail = 1'b1;
            end
        end

        // sequence start, or truncation if the string ends too soon
        if (do_start) begin
            if (after < need) begin
                do_fail   = 1'b1;
                fail_kind = KIND_TRUNC;
            end else begin
                o_state.bytes_pending = need;
                o_state.code_accum    = start_bits;
            end
        end

        // code point to escapes
        off = cp - CP_W'(32'h10000);
        if (emit_cp) begin
            if (cp < CP_W'(32'h10000)) begin
                cnt    = 2'd1;
                o_res0 = '{kind: KIND_U4, value: cp, last_of_run: 1'b0};
            end else if (i_cfg.surrogate_pairs) begin
                cnt    = 2'd2;
                o_res0 = '{kind: KIND_U4, value: CP_W'({6'h36, off[19:10]}),
                           last_of_run: 1'b0};
                o_res1 = '{kind: KIND_U4, value: CP_W'({6'h37, off[9:0]}),
                           last_of_run: 1'b0};
            end else begin
                cnt    = 2'd1;
                o_res0 = '{kind: KIND_U8, value: cp, last_of_run: 1'b0};
            end
        end

        // first error: report and drop the rest
        if (do_fail) begin
            cnt                   = 2'd1;
            o_res0                = '{kind: fail_kind,
                                      value: (fail_kind == KIND_BAD) ? CP_W'(b) : '0,
                                      last_of_run: 1'b0};
            o_state.drop_rest     = 1'b1;
            o_state.bytes_pending = 2'd0;
            o_state.code_accum    = '0;
        end

        // end of string resets everything
        if (after == 2'd0) begin
            o_state = '0;
        end

        if (cnt == 2'd1) begin
            o_res0.last_of_run = 1'b1;
        end else if (cnt == 2'd2) begin
            o_res1.last_of_run = 1'b1;
        end
        o_count = cnt;
    end

endmodule

[verif/utf8_string_escaper_unit_tb.sv]
`timescale 1ns / 1ps

module utf8_string_escaper_unit_tb;
    import utf8e_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;  // spare code, decodes as utf8
    localparam int LIVE_TARGET = 1000;          // bytes decoded outside a dropped string tail
    localparam int PHASE_BYTES = 150;
    localparam int DRAIN_CYCLES = 4;            // two-stage pipe plus margin
    localparam int CYCLE_LIMIT = 1000000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    t_in_item              i_data = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    t_out_item             o_data;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Shadow decoder state and configuration
    logic [1:0]      dec_pend;
    logic [CP_W-1:0] dec_accum;
    logic            dec_drop;
    logic [1:0]      cfg_mode;
    logic            cfg_surr;

    t_in_item   byte_q[$];      // bytes waiting to be sent
    t_out_item  escaped_q[$];   // escape results still owed by the block
    logic [7:0] str_buf[$];     // string under construction

    int tx_wait, rx_wait, tx_max, rx_max;
    int live_items, n_bytes, n_results, err_cnt, cycle_cnt, n_phases;
    t_out_item want;

    utf8_string_escaper_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Escape predictor
    // ---------------------------------------------------------------
    function automatic void push_result(logic [2:0] k, logic [CP_W-1:0] v);
        t_out_item r;
        r.kind = k;
        r.value = v;
        r.last_of_run = 1'b0;
        escaped_q.push_back(r);
    endfunction

    function automatic void push_code_point(logic [CP_W-1:0] cp);
        logic [CP_W-1:0] off;
        if (cp < 21'h10000) begin
            push_result(KIND_U4, cp);
        end else if (cfg_surr) begin
            off = cp - 21'h10000;
            push_result(KIND_U4, 21'hD800 | 21'(off[19:10]));
            push_result(KIND_U4, 21'hDC00 | 21'(off[9:0]));
        end else begin
            push_result(KIND_U8, cp);
        end
    endfunction

    // First error of a string: report it and ignore the remainder
    function automatic void flag_error(logic [2:0] k, logic [CP_W-1:0] v);
        dec_drop = 1'b1;
        dec_pend = '0;
        dec_accum = '0;
        push_result(k, v);
    endfunction

    function automatic void open_sequence(logic [1:0] after, logic [1:0] need,
                                          logic [CP_W-1:0] bits);
        if (after < need) begin
            flag_error(KIND_TRUNC, '0);
        end else begin
            dec_pend = need;
            dec_accum = bits;
        end
    endfunction

    function automatic bit is_plain(logic [7:0] b);
        return b >= 8'd32 && b <= 8'd127 && b != 8'h22 && b != 8'h5C;
    endfunction

    function automatic void predict_escape(t_in_item it);
        logic [7:0] b;
        logic [1:0] after;
        int n0;
        b = it.data_byte;
        after = it.bytes_after;
        n0 = escaped_q.size();
        if (dec_drop) begin
            // rest of a failed string is silent
        end else if (dec_pend != 0) begin
            // continuation expected, whatever the mode is now
            if (b[7:6] != 2'b10) begin
                flag_error(KIND_BAD, 21'(b));
            end else begin
                dec_accum = {dec_accum[CP_W-7:0], b[5:0]};
                dec_pend = dec_pend - 2'd1;
                if (dec_pend == 0) begin
                    push_code_point(dec_accum);
                    dec_accum = '0;
                end else if (after == 0) begin
                    flag_error(KIND_TRUNC, '0);
                end
            end
        end else if (cfg_mode == MODE_LATIN1) begin
            if (is_plain(b)) push_result(KIND_LIT, 21'(b));
            else push_code_point(21'(b));
        end else if (cfg_mode == MODE_MIXED) begin
            if (is_plain(b)) push_result(KIND_LIT, 21'(b));
            else if (b[7:5] == 3'b110) open_sequence(after, 2'd1, 21'(b[4:0]));
            else push_code_point(21'(b));
        end else begin
            // utf8, also the spare mode code
            if (!b[7]) begin
                if (is_plain(b)) push_result(KIND_LIT, 21'(b));
                else push_code_point(21'(b));
            end else if (b[7:5] == 3'b110) begin
                if (b == 8'hC0 || b == 8'hC1) flag_error(KIND_BAD, 21'(b));
                else open_sequence(after, 2'd1, 21'(b[4:0]));
            end else if (b[7:4] == 4'b1110) begin
                open_sequence(after, 2'd2, 21'(b[3:0]));
            end else if (b[7:3] == 5'b11110) begin
                if (b >= 8'hF5) flag_error(KIND_BAD, 21'(b));
                else open_sequence(after, 2'd3, 21'(b[2:0]));
            end else begin
                flag_error(KIND_BAD, 21'(b));
            end
        end
        // end of string clears everything
        if (after == 0) begin
            dec_pend = '0;
            dec_accum = '0;
            dec_drop = 1'b0;
        end
        if (escaped_q.size() > n0)
            escaped_q[escaped_q.size()-1].last_of_run = 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic int draw_wait(int max_wait);
        if (max_wait == 0 || $urandom_range(0, 1) == 0) return 0;
        return $urandom_range(1, max_wait);
    endfunction

    function automatic void push_byte(logic [7:0] b, logic [1:0] after);
        t_in_item it;
        it.data_byte = b;
        it.bytes_after = after;
        byte_q.push_back(it);
    endfunction

    function automatic logic [7:0] cont_byte();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    // One character, mostly well formed for the given mode
    function automatic void add_char(logic [1:0] mode);
        int sel;
        logic [7:0] lead;
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
            str_buf.push_back(8'($urandom_range(32, 126)));
        end else if (sel < 50) begin
            case ($urandom_range(0, 3))
                0: str_buf.push_back(8'h22);
                1: str_buf.push_back(8'h5C);
                2: str_buf.push_back(8'h7F);
                default: str_buf.push_back(8'($urandom_range(0, 31)));
            endcase
        end else if (mode == MODE_LATIN1 || sel < 56) begin
            str_buf.push_back(8'($urandom_range(0, 255)));
        end else if (sel < 72 || mode == MODE_MIXED) begin
            lead = 8'($urandom_range(mode == MODE_MIXED ? 8'hC0 : 8'hC2, 8'hDF));
            str_buf.push_back(lead);
            str_buf.push_back(cont_byte());
        end else if (sel < 86) begin
            str_buf.push_back(8'($urandom_range(8'hE0, 8'hEF)));
            str_buf.push_back(cont_byte());
            str_buf.push_back(cont_byte());
        end else begin
            str_buf.push_back(8'($urandom_range(8'hF0, 8'hF4)));
            str_buf.push_back(cont_byte());
            str_buf.push_back(cont_byte());
            str_buf.push_back(cont_byte());
        end
    endfunction

    // Build a string and queue it; returns the byte count
    function automatic int add_string(logic [1:0] mode);
        int nchar, rem;
        logic [1:0] after;
        str_buf.delete();
        nchar = $urandom_range(1, 10);
        for (int c = 0; c < nchar; c++) add_char(mode);
        // sometimes cut the string inside its last character
        if (str_buf.size() > 1 && $urandom_range(0, 9) == 0) void'(str_buf.pop_back());
        for (int i = 0; i < str_buf.size(); i++) begin
            rem = str_buf.size() - 1 - i;
            after = (rem > 3) ? 2'd3 : 2'(rem);
            // rare bogus count of bytes to come
            if ($urandom_range(0, 49) == 0) after = 2'($urandom_range(0, 3));
            push_byte(str_buf[i], after);
        end
        return str_buf.size();
    endfunction

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        if (idx == CFG_ENC_MODE) cfg_mode = data;
        else cfg_surr = data[0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (byte_q.size() != 0 || i_valid || escaped_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // Input driver
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            tx_wait = 0;
        end else begin
            if (i_valid && !o_stall) begin
                if (!dec_drop) live_items++;
                n_bytes++;
                predict_escape(i_data);
                tx_wait = draw_wait(tx_max);
            end
            if (!i_valid || !o_stall) begin
                if (tx_wait == 0 && byte_q.size() != 0) begin
                    i_valid <= 1'b1;
                    i_data <= byte_q.pop_front();
                end else begin
                    i_valid <= 1'b0;
                    if (tx_wait > 0) tx_wait--;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Output monitor and checker
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            rx_wait = 0;
        end else begin
            if (o_valid && !i_stall) begin
                n_results++;
                if (escaped_q.size() == 0) begin
                    $error("unexpected result: kind %0d value 0x%0h last %0b",
                           o_data.kind, o_data.value, o_data.last_of_run);
                    err_cnt++;
                end else begin
                    want = escaped_q.pop_front();
                    if (o_data.kind !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, o_data.kind);
                        err_cnt++;
                    end
                    if (o_data.value !== want.value) begin
                        $error("value: expected 0x%0h, got 0x%0h", want.value, o_data.value);
                        err_cnt++;
                    end
                    if (o_data.last_of_run !== want.last_of_run) begin
                        $error("last_of_run: expected %0b, got %0b",
                               want.last_of_run, o_data.last_of_run);
                        err_cnt++;
                    end
                end
                rx_wait = draw_wait(rx_max);
            end
            if (rx_wait > 0) begin
                i_stall <= 1'b1;
                rx_wait--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still owed",
                     cycle_cnt, escaped_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial begin
        logic [1:0] mode_seq[4];
        logic [1:0] mode;
        logic       surr;
        bit         carry_open;
        int         phase_bytes;

        mode_seq = '{MODE_UTF8, MODE_LATIN1, MODE_MIXED, MODE_UNUSED};
        dec_pend = '0;
        dec_accum = '0;
        dec_drop = 1'b0;
        cfg_mode = MODE_UTF8;
        cfg_surr = 1'b1;
        tx_max = 16;
        rx_max = 16;
        live_items = 0;
        n_bytes = 0;
        n_results = 0;
        err_cnt = 0;
        cycle_cnt = 0;
        n_phases = 0;
        carry_open = 1'b0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed bytes under reset configuration (utf8, surrogate pairs)
        // ASCII edges: space, DEL, quote, backslash, NUL, unit separator
        push_byte(8'h20, 2'd3);
        push_byte(8'h7F, 2'd3);
        push_byte(8'h22, 2'd3);
        push_byte(8'h5C, 2'd2);
        push_byte(8'h00, 2'd1);
        push_byte(8'h1F, 2'd0);
        // four-byte character split into a surrogate pair
        push_byte(8'hF0, 2'd3);
        push_byte(8'h9F, 2'd2);
        push_byte(8'h98, 2'd1);
        push_byte(8'h80, 2'd0);
        // largest lead F4 with all-ones continuations
        push_byte(8'hF4, 2'd3);
        push_byte(8'hBF, 2'd2);
        push_byte(8'hBF, 2'd1);
        push_byte(8'hBF, 2'd0);
        // overlong two-byte lead, then a dropped byte
        push_byte(8'hC0, 2'd1);
        push_byte(8'h41, 2'd0);
        // bad lead at end of string
        push_byte(8'hFF, 2'd0);
        // lead too near the end
        push_byte(8'hE2, 2'd1);
        push_byte(8'h82, 2'd0);
        // end marked inside a sequence
        push_byte(8'hE2, 2'd3);
        push_byte(8'h82, 2'd0);
        // too-large four-byte lead, stray continuation as lead
        push_byte(8'hF5, 2'd0);
        push_byte(8'h80, 2'd0);
        drain();

        // Random phases, each under its own register setting
        while (live_items < LIVE_TARGET) begin
            if (n_phases < 8) begin
                mode = mode_seq[n_phases % 4];
                surr = (n_phases >= 4);
            end else begin
                mode = mode_seq[$urandom_range(0, 3)];
                surr = 1'($urandom);
            end
            write_cfg(CFG_ENC_MODE, mode);
            write_cfg(CFG_SURR_PAIR, {1'($urandom), surr});
            tx_max = ($urandom_range(0, 3) == 0) ? 0 : 16;
            rx_max = ($urandom_range(0, 3) == 0) ? 0 : 16;

            // finish a sequence left open across the register change
            if (carry_open) push_byte(cont_byte(), 2'd0);
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) phase_bytes += add_string(mode);
            carry_open = ($urandom_range(0, 2) == 0);
            if (carry_open) push_byte(8'($urandom_range(8'hC2, 8'hDF)), 2'd1);
            drain();
            n_phases++;
        end
        if (carry_open) begin
            push_byte(cont_byte(), 2'd0);
            drain();
        end
        repeat (8) @(posedge i_clk);

        $display("Run covered %0d bytes (%0d decoded) across %0d register settings,",
                 n_bytes, live_items, n_phases);
        $display("checking %0d escape results against the predictor.", n_results);
        if (err_cnt == 0 && escaped_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches, %0d results missing", err_cnt, escaped_q.size());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
